[hdl/apt_pkg.sv]
// Shared types and constants of the affine point transform block.
package apt_pkg;

    localparam int unsigned PixelBitsDefault = 6;
    localparam int unsigned PixelBitsBase    = 6;

    localparam int unsigned CoordW  = 24;   // Q.6 input coordinates and offsets
    localparam int unsigned CoefW   = 32;   // Q16.16 matrix terms
    localparam int unsigned ValW    = 32;   // saturated Q.6 transform result
    localparam int unsigned PixW    = 26;   // whole-pixel box coordinates
    localparam int unsigned ClipW   = 16;   // clip corner coordinates
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 32;

    localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
    localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};

    localparam logic [CoefW-1:0]  CoefOne       = 32'h0001_0000;
    localparam logic [CfgDataW-1:0] ClipLowReset  = 32'h0000_0000;
    localparam logic [CfgDataW-1:0] ClipHighReset = 32'hFFFF_FFFF;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SCALE_XX  = 3'd0,
        CFG_SHEAR_XY  = 3'd1,
        CFG_OFFSET_X  = 3'd2,
        CFG_SHEAR_YX  = 3'd3,
        CFG_SCALE_YY  = 3'd4,
        CFG_OFFSET_Y  = 3'd5,
        CFG_CLIP_LOW  = 3'd6,
        CFG_CLIP_HIGH = 3'd7
    } t_cfg_idx;

    // Load enables of the three transform stages
    typedef struct packed {
        logic prod;
        logic sum;
        logic quant;
    } t_xf_en;

endpackage

[hdl/apt_xform.sv]
// One output axis of the affine transform: products, sum, truncation and saturation.
module apt_xform
    import apt_pkg::*;
(
    input  logic                     i_clk,
    input  t_xf_en                   i_en,
    input  logic signed [CoordW-1:0] i_x,
    input  logic signed [CoordW-1:0] i_y,
    input  logic signed [CoefW-1:0]  i_coef_x,
    input  logic signed [CoefW-1:0]  i_coef_y,
    input  logic signed [CoordW-1:0] i_offset,
    output logic signed [ValW-1:0]   o_val
);

    localparam int unsigned ProdW = CoordW + CoefW;
    localparam int unsigned SumW  = ProdW + 2;
    localparam int unsigned FracW = 16;
    localparam int unsigned QW    = SumW - FracW;

    logic signed [ProdW-1:0] r_prod_x, r_prod_y, n_prod_x, n_prod_y;
    logic signed [CoordW-1:0] r_offset;
    logic signed [SumW-1:0]  r_sum, n_sum;
    logic signed [QW-1:0]    w_q;
    logic signed [ValW-1:0]  r_val, n_val;

    always_comb begin
        n_prod_x = i_x * i_coef_x;
        n_prod_y = i_y * i_coef_y;
    end

    always_comb begin
        n_sum = {{2{r_prod_x[ProdW-1]}}, r_prod_x}
              + {{2{r_prod_y[ProdW-1]}}, r_prod_y}
              + {{(SumW-CoordW-FracW){r_offset[CoordW-1]}}, r_offset, {FracW{1'b0}}};
    end

    // Truncate toward zero: floor, then step up for negative values with a fraction
    always_comb begin
        w_q = r_sum[SumW-1:FracW];
        if (r_sum[SumW-1] && (|r_sum[FracW-1:0])) begin
            w_q = w_q + QW'(1);
        end
        if (w_q[QW-1:ValW-1] == {(QW-ValW+1){w_q[QW-1]}}) begin
            n_val = w_q[ValW-1:0];
        end else if (w_q[QW-1]) begin
            n_val = ValMin;
        end else begin
            n_val = ValMax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
            r_offset <= i_offset;
        end
        if (i_en.sum) begin
            r_sum <= n_sum;
        end
        if (i_en.quant) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

[hdl/apt_pixbox.sv]
// One axis of the render box: round to whole pixels, intersect with the clip range.
module apt_pixbox
    import apt_pkg::*;
(
    input  logic signed [ValW-1:0]  i_min,
    input  logic signed [ValW-1:0]  i_max,
    input  logic                    i_fast,
    input  logic signed [ClipW-1:0] i_clip_lo,
    input  logic signed [ClipW-1:0] i_clip_hi,
    output logic signed [PixW-1:0]  o_lo,
    output logic signed [PixW-1:0]  o_hi,
    output logic                    o_open
);

    localparam int unsigned WorkW = PixW + 2;

    logic signed [WorkW-1:0] w_lo_raw, w_hi_raw, w_clo, w_chi, w_lo, w_hi_cl, w_hi;

    // Nearest pixel, halves away from zero
    function automatic logic signed [WorkW-1:0] f_round(input logic signed [ValW-1:0] v);
        logic [ValW:0]   mag;
        logic [ValW+1:0] biased;
        logic [WorkW-1:0] r;
        mag    = v[ValW-1] ? (ValW+1)'(-{v[ValW-1], v}) : {1'b0, v};
        biased = {1'b0, mag} + (ValW+2)'(32);
        r      = biased[ValW+1:6];
        return v[ValW-1] ? -r : r;
    endfunction

    function automatic logic signed [WorkW-1:0] f_floor(input logic signed [ValW-1:0] v);
        logic signed [ValW-1:0] s;
        s = v >>> 6;
        return WorkW'(s[ValW-7:0]) | {{(WorkW-ValW+6){s[ValW-7]}}, {(ValW-6){1'b0}}};
    endfunction

    function automatic logic signed [WorkW-1:0] f_ceil(input logic signed [ValW-1:0] v);
        logic signed [ValW:0] b;
        b = {v[ValW-1], v} + (ValW+1)'(63);
        b = b >>> 6;
        return {{(WorkW-ValW+5){b[ValW-6]}}, b[ValW-6:0]};
    endfunction

    always_comb begin
        if (i_fast) begin
            w_lo_raw = f_round(i_min);
            w_hi_raw = f_round(i_max);
        end else begin
            w_lo_raw = f_floor(i_min);
            w_hi_raw = f_ceil(i_max);
        end
        w_clo   = {{(WorkW-ClipW){i_clip_lo[ClipW-1]}}, i_clip_lo};
        w_chi   = {{(WorkW-ClipW){i_clip_hi[ClipW-1]}}, i_clip_hi};
        w_lo    = (w_lo_raw < w_clo) ? w_clo : w_lo_raw;
        w_hi_cl = (w_hi_raw > w_chi) ? w_chi : w_hi_raw;
        // Raise a maximum that fell below the minimum
        w_hi    = (w_hi_cl < w_lo) ? w_lo : w_hi_cl;
    end

    assign o_lo   = w_lo[PixW-1:0];
    assign o_hi   = w_hi[PixW-1:0];
    assign o_open = (w_hi > w_lo);

endmodule

[hdl/affine_point_transform_bbox_clip_top.sv]
// Top level of the affine point transform with path bounding box and clipped render box.
// Takes one path point per clock when the output side does not stall and returns one
// result per point. Each point passes an input register, a 24x32 multiply stage, a sum
// stage, a truncate-and-saturate stage, the running box stage and the result register;
// the min/max update of the running box sets the rate of one point per clock. On a point
// marked path_end the result also carries the path box and the clipped whole-pixel render
// box, and the running box starts afresh for the next path. The user must write
// configuration only while no point is in flight; the block does not enforce this.
module affine_point_transform_bbox_clip_top
    import apt_pkg::*;
#(
    parameter int unsigned PIXEL_BITS = PixelBitsDefault
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CfgIdxW-1:0]         i_cfg_idx,
    input  logic [CfgDataW-1:0]        i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [CoordW-1:0]   i_pt_x,
    input  logic signed [CoordW-1:0]   i_pt_y,
    input  logic                       i_path_end,
    input  logic                       i_fast_track,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [ValW-1:0]     o_out_x,
    output logic signed [ValW-1:0]     o_out_y,
    output logic signed [ValW-1:0]     o_bound_min_x,
    output logic signed [ValW-1:0]     o_bound_min_y,
    output logic signed [ValW-1:0]     o_bound_max_x,
    output logic signed [ValW-1:0]     o_bound_max_y,
    output logic signed [PixW-1:0]     o_box_min_x,
    output logic signed [PixW-1:0]     o_box_min_y,
    output logic signed [PixW-1:0]     o_box_max_x,
    output logic signed [PixW-1:0]     o_box_max_y,
    output logic                       o_box_valid,
    output logic                       o_box_ready
);

    localparam int unsigned PixelShift = PIXEL_BITS - PixelBitsBase;

    // Configuration registers
    logic signed [CoefW-1:0]  r_scale_xx, r_shear_xy, r_shear_yx, r_scale_yy;
    logic signed [CoordW-1:0] r_offset_x, r_offset_y;
    logic [CfgDataW-1:0]      r_clip_lo, r_clip_hi;

    // Stage valids: a input, b product, c sum, d quantised, e box, f result
    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_f_v;
    logic w_a_en, w_b_en, w_c_en, w_d_en, w_e_en, w_f_en;

    logic signed [CoordW-1:0] r_a_x, r_a_y;
    logic r_a_last, r_b_last, r_c_last, r_d_last, r_e_last;
    logic r_a_fast, r_b_fast, r_c_fast, r_d_fast, r_e_fast;

    t_xf_en w_xf_en;
    logic signed [ValW-1:0] w_d_tx, w_d_ty;

    logic signed [ValW-1:0] r_run_min_x, r_run_min_y, r_run_max_x, r_run_max_y;
    logic signed [ValW-1:0] n_min_x, n_min_y, n_max_x, n_max_y;
    logic signed [ValW-1:0] r_e_tx, r_e_ty;
    logic signed [ValW-1:0] r_e_min_x, r_e_min_y, r_e_max_x, r_e_max_y;

    logic signed [PixW-1:0] w_lo_x, w_hi_x, w_lo_y, w_hi_y;
    logic w_open_x, w_open_y;

    logic signed [ValW-1:0] r_f_x, r_f_y;
    logic signed [ValW-1:0] r_f_min_x, r_f_min_y, r_f_max_x, r_f_max_y;
    logic signed [PixW-1:0] r_f_lo_x, r_f_lo_y, r_f_hi_x, r_f_hi_y;
    logic r_f_box_valid, r_f_box_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_xx <= CoefOne;
            r_shear_xy <= '0;
            r_offset_x <= '0;
            r_shear_yx <= '0;
            r_scale_yy <= CoefOne;
            r_offset_y <= '0;
            r_clip_lo  <= ClipLowReset;
            r_clip_hi  <= ClipHighReset;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SCALE_XX:  r_scale_xx <= i_cfg_data;
                CFG_SHEAR_XY:  r_shear_xy <= i_cfg_data;
                CFG_OFFSET_X:  r_offset_x <= i_cfg_data[CoordW-1:0];
                CFG_SHEAR_YX:  r_shear_yx <= i_cfg_data;
                CFG_SCALE_YY:  r_scale_yy <= i_cfg_data;
                CFG_OFFSET_Y:  r_offset_y <= i_cfg_data[CoordW-1:0];
                CFG_CLIP_LOW:  r_clip_lo  <= i_cfg_data;
                CFG_CLIP_HIGH: r_clip_hi  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage may load when empty or when its beat moves on
    always_comb begin
        w_f_en = !r_f_v || i_out_ready;
        w_e_en = !r_e_v || w_f_en;
        w_d_en = !r_d_v || w_e_en;
        w_c_en = !r_c_v || w_d_en;
        w_b_en = !r_b_v || w_c_en;
        w_a_en = !r_a_v || w_b_en;
    end

    assign o_in_ready    = w_a_en;
    assign w_xf_en.prod  = w_b_en;
    assign w_xf_en.sum   = w_c_en;
    assign w_xf_en.quant = w_d_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else begin
            if (w_a_en) r_a_v <= i_in_valid;
            if (w_b_en) r_b_v <= r_a_v;
            if (w_c_en) r_c_v <= r_b_v;
            if (w_d_en) r_d_v <= r_c_v;
            if (w_e_en) r_e_v <= r_d_v;
            if (w_f_en) r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_en) begin
            r_a_x    <= i_pt_x;
            r_a_y    <= i_pt_y;
            r_a_last <= i_path_end;
            r_a_fast <= i_fast_track;
        end
        if (w_b_en) begin
            r_b_last <= r_a_last;
            r_b_fast <= r_a_fast;
        end
        if (w_c_en) begin
            r_c_last <= r_b_last;
            r_c_fast <= r_b_fast;
        end
        if (w_d_en) begin
            r_d_last <= r_c_last;
            r_d_fast <= r_c_fast;
        end
    end

    apt_xform u_xform_x (
        .i_clk    (i_clk),
        .i_en     (w_xf_en),
        .i_x      (r_a_x),
        .i_y      (r_a_y),
        .i_coef_x (r_scale_xx),
        .i_coef_y (r_shear_xy),
        .i_offset (r_offset_x),
        .o_val    (w_d_tx)
    );

    apt_xform u_xform_y (
        .i_clk    (i_clk),
        .i_en     (w_xf_en),
        .i_x      (r_a_x),
        .i_y      (r_a_y),
        .i_coef_x (r_shear_yx),
        .i_coef_y (r_scale_yy),
        .i_offset (r_offset_y),
        .o_val    (w_d_ty)
    );

    always_comb begin
        n_min_x = (w_d_tx < r_run_min_x) ? w_d_tx : r_run_min_x;
        n_max_x = (w_d_tx > r_run_max_x) ? w_d_tx : r_run_max_x;
        n_min_y = (w_d_ty < r_run_min_y) ? w_d_ty : r_run_min_y;
        n_max_y = (w_d_ty > r_run_max_y) ? w_d_ty : r_run_max_y;
    end

    // Running box: fold in each point, start afresh after the last point of a path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_min_x <= ValMax;
            r_run_min_y <= ValMax;
            r_run_max_x <= ValMin;
            r_run_max_y <= ValMin;
        end else if (w_e_en && r_d_v) begin
            if (r_d_last) begin
                r_run_min_x <= ValMax;
                r_run_min_y <= ValMax;
                r_run_max_x <= ValMin;
                r_run_max_y <= ValMin;
            end else begin
                r_run_min_x <= n_min_x;
                r_run_min_y <= n_min_y;
                r_run_max_x <= n_max_x;
                r_run_max_y <= n_max_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_e_en) begin
            r_e_tx    <= w_d_tx;
            r_e_ty    <= w_d_ty;
            r_e_min_x <= n_min_x;
            r_e_min_y <= n_min_y;
            r_e_max_x <= n_max_x;
            r_e_max_y <= n_max_y;
            r_e_last  <= r_d_last;
            r_e_fast  <= r_d_fast;
        end
    end

    apt_pixbox u_pixbox_x (
        .i_min     (r_e_min_x),
        .i_max     (r_e_max_x),
        .i_fast    (r_e_fast),
        .i_clip_lo (r_clip_lo[ClipW-1:0]),
        .i_clip_hi (r_clip_hi[ClipW-1:0]),
        .o_lo      (w_lo_x),
        .o_hi      (w_hi_x),
        .o_open    (w_open_x)
    );

    apt_pixbox u_pixbox_y (
        .i_min     (r_e_min_y),
        .i_max     (r_e_max_y),
        .i_fast    (r_e_fast),
        .i_clip_lo (r_clip_lo[2*ClipW-1:ClipW]),
        .i_clip_hi (r_clip_hi[2*ClipW-1:ClipW]),
        .o_lo      (w_lo_y),
        .o_hi      (w_hi_y),
        .o_open    (w_open_y)
    );

    // Result register; box fields stay zero except on the last point
    always_ff @(posedge i_clk) begin
        if (w_f_en) begin
            r_f_x         <= r_e_tx << PixelShift;
            r_f_y         <= r_e_ty << PixelShift;
            r_f_min_x     <= r_e_last ? r_e_min_x : '0;
            r_f_min_y     <= r_e_last ? r_e_min_y : '0;
            r_f_max_x     <= r_e_last ? r_e_max_x : '0;
            r_f_max_y     <= r_e_last ? r_e_max_y : '0;
            r_f_lo_x      <= r_e_last ? w_lo_x : '0;
            r_f_lo_y      <= r_e_last ? w_lo_y : '0;
            r_f_hi_x      <= r_e_last ? w_hi_x : '0;
            r_f_hi_y      <= r_e_last ? w_hi_y : '0;
            r_f_box_valid <= r_e_last && w_open_x && w_open_y;
            r_f_box_ready <= r_e_last;
        end
    end

    assign o_out_valid   = r_f_v;
    assign o_out_x       = r_f_x;
    assign o_out_y       = r_f_y;
    assign o_bound_min_x = r_f_min_x;
    assign o_bound_min_y = r_f_min_y;
    assign o_bound_max_x = r_f_max_x;
    assign o_bound_max_y = r_f_max_y;
    assign o_box_min_x   = r_f_lo_x;
    assign o_box_min_y   = r_f_lo_y;
    assign o_box_max_x   = r_f_hi_x;
    assign o_box_max_y   = r_f_hi_y;
    assign o_box_valid   = r_f_box_valid;
    assign o_box_ready   = r_f_box_ready;

    a_box_valid_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_box_valid |-> o_box_ready && (o_box_max_x > o_box_min_x)
                                       && (o_box_max_y > o_box_min_y))
        else $error("box_valid without a last point or with an empty box");

    a_bounds_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_box_ready |-> (o_bound_min_x == '0) && (o_bound_max_y == '0)
                                        && (o_box_min_x == '0) && (o_box_max_y == '0))
        else $error("box fields set on a point that is not last");

    a_run_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_e_en && r_d_v && r_d_last |=> (r_run_min_x == ValMax) && (r_run_max_y == ValMin))
        else $error("running box not cleared after the last point");

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_box_ready |-> (o_box_max_x >= o_box_min_x)
                                       && (o_box_max_y >= o_box_min_y))
        else $error("render box maximum below minimum");

endmodule
